@@ hdl/assert_macros.svh @@
// Assertion macros used by the port checker of the threshold signal block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while the synchronous reset is held.
`define RSITS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion that is also checked across the reset itself.
`define RSITS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ hdl/rsits_pkg.sv @@
// Package of types, constants and codes shared by the RSI threshold signal block.
`timescale 1ns / 1ps

package rsits_pkg;

    // Default sizing of the block.
    localparam int WINDOW_MAX_DEF = 64;
    localparam int PRICE_BITS_DEF = 32;
    localparam int SUM_W_DEF      = PRICE_BITS_DEF + $clog2(WINDOW_MAX_DEF);

    // Fixed field widths.
    localparam int WLEN_W     = 7;
    localparam int RSI_W      = 14;
    localparam int SIG_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // The quotient is formed as four decimal digits, each of four bits.
    localparam int RSI_DIGITS = 4;
    localparam int DIGIT_BITS = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERBOUGHT_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERSOLD_LEVEL   = 2'd2;

    // Reset values.
    localparam logic [WLEN_W-1:0] WLEN_RESET     = 7'd14;
    localparam logic [RSI_W-1:0]  OVERBOUGHT_RST = 14'd7000;
    localparam logic [RSI_W-1:0]  OVERSOLD_RST   = 14'd3000;
    localparam logic [RSI_W-1:0]  RSI_INIT       = 14'd5000;
    localparam logic [RSI_W-1:0]  RSI_FULL       = 14'd10000;

    // Trade signal codes.
    typedef enum logic [SIG_W-1:0] {
        SIG_HOLD = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } t_trade_signal;

    // Result of the divider towards the control sequencer.
    typedef struct packed {
        logic             done;
        logic [RSI_W-1:0] quo;
    } t_div_res;

endpackage

@@ hdl/rsits_div.sv @@
// Digit-serial divider forming floor(10000 * gain / total), one quotient bit per trial subtraction.
`timescale 1ns / 1ps

module rsits_div #(
    parameter int SUM_W = rsits_pkg::SUM_W_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SUM_W-1:0]    i_gain,
    input  logic [SUM_W-1:0]    i_total,
    output rsits_pkg::t_div_res o_res
);

    // Ten times a remainder below the divisor needs four more bits.
    localparam int REM_W = SUM_W + 4;
    localparam int DB    = rsits_pkg::DIGIT_BITS;
    localparam int RW    = rsits_pkg::RSI_W;

    typedef enum logic [1:0] {
        D_IDLE,
        D_SCALE,
        D_STEP
    } t_dstate;

    t_dstate                 r_state, n_state;
    logic                    r_done, n_done;
    logic [REM_W-1:0]        r_rem, n_rem;
    logic [SUM_W-1:0]        r_den, n_den;
    logic [RW-1:0]           r_quo, n_quo;
    logic [DB-1:0]           r_digit, n_digit;
    logic [1:0]              r_bit, n_bit;
    logic [1:0]              r_dig_cnt, n_dig_cnt;

    logic [REM_W-1:0]        den_sh;
    logic [REM_W:0]          trial;
    logic [DB-1:0]           digit_new;

    // Trial subtraction of the divisor scaled by the current digit weight.
    assign den_sh    = REM_W'(r_den) << r_bit;
    assign trial     = {1'b0, r_rem} - {1'b0, den_sh};
    assign digit_new = trial[REM_W] ? r_digit : (r_digit | (DB'(1) << r_bit));

    always_comb begin
        n_state   = r_state;
        n_done    = 1'b0;
        n_rem     = r_rem;
        n_den     = r_den;
        n_quo     = r_quo;
        n_digit   = r_digit;
        n_bit     = r_bit;
        n_dig_cnt = r_dig_cnt;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_rem     = REM_W'(i_gain);
                    n_den     = i_total;
                    n_quo     = '0;
                    n_dig_cnt = '0;
                    n_state   = D_SCALE;
                end
            end
            D_SCALE: begin
                n_rem   = (r_rem << 3) + (r_rem << 1);
                n_digit = '0;
                n_bit   = 2'(DB - 1);
                n_state = D_STEP;
            end
            D_STEP: begin
                if (!trial[REM_W]) begin
                    n_rem = trial[REM_W-1:0];
                end
                n_digit = digit_new;
                if (r_bit == 2'd0) begin
                    n_quo = RW'((r_quo << 3) + (r_quo << 1) + RW'(digit_new));
                    if (r_dig_cnt == 2'(rsits_pkg::RSI_DIGITS - 1)) begin
                        n_done  = 1'b1;
                        n_state = D_IDLE;
                    end else begin
                        n_dig_cnt = r_dig_cnt + 2'd1;
                        n_state   = D_SCALE;
                    end
                end else begin
                    n_bit = r_bit - 2'd1;
                end
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_rem     <= n_rem;
        r_den     <= n_den;
        r_quo     <= n_quo;
        r_digit   <= n_digit;
        r_bit     <= n_bit;
        r_dig_cnt <= n_dig_cnt;
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;

endmodule

@@ hdl/rsi_threshold_signal_top.sv @@
// Top level of the RSI threshold signal block: window store, running sums and signal logic.
`timescale 1ns / 1ps

// Each accepted item is one closing price. When a previous nonzero price exists, the
// price change is stored in a ring of the last window_length changes and exact sums of
// gains and losses are kept. Once the window is full the RSI, in hundredths of a percent
// point, is 10000 * G / (G + L) truncated, or 10000 when the loss sum is zero; otherwise it
// keeps its last value, 5000 after reset. Every item gives exactly one result: SELL above
// the overbought level, BUY below the oversold level, HOLD otherwise and always HOLD before
// the window has filled. Items are handled one at a time. An item whose price has no
// predecessor goes from acceptance straight to the signal step; one that updates the
// window passes the change, remove, add and check steps, and the divider when a new
// quotient is needed, which produces four decimal digits at one bit per cycle (one scaling
// step and four trial subtractions per digit). The result sits in an output register, so
// a new item is taken while the previous result still waits. A write to window_length
// empties the window but keeps the previous price and the held RSI. Configuration writes
// are taken only while no item is in progress, and input items are stalled during a
// configuration write. The change store has no reset: the fill count makes sure that an
// entry is read back only after it has been written, so no clearing pass is needed.
module rsi_threshold_signal_top #(
    parameter int WINDOW_MAX = rsits_pkg::WINDOW_MAX_DEF,
    parameter int PRICE_BITS = rsits_pkg::PRICE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input items.
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [PRICE_BITS-1:0]            i_close_price,
    // Result items.
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [rsits_pkg::SIG_W-1:0]      o_trade_signal,
    output logic [rsits_pkg::RSI_W-1:0]      o_rsi_level,
    output logic                             o_window_full,
    // Configuration writes.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rsits_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rsits_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int P      = PRICE_BITS;
    localparam int SLOT_W = $clog2(WINDOW_MAX);
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = PRICE_BITS + $clog2(WINDOW_MAX);
    localparam int WL_W   = rsits_pkg::WLEN_W;
    localparam int CMP_W  = (LEN_W > WL_W) ? LEN_W : WL_W;
    localparam int RW     = rsits_pkg::RSI_W;

    // Sequencer states: the window update runs through the stored sums one step at a time.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHANGE,
        S_REMOVE,
        S_ADD,
        S_CHECK,
        S_DIVIDE,
        S_SIGNAL
    } t_state;

    t_state                   r_state, n_state;

    // Configuration registers.
    logic [WL_W-1:0]          r_window_length, n_window_length;
    logic [RW-1:0]            r_overbought, n_overbought;
    logic [RW-1:0]            r_oversold, n_oversold;

    // Window state.
    logic [LEN_W-1:0]         r_fill, n_fill;
    logic [SLOT_W-1:0]        r_wslot, n_wslot;
    logic [SUM_W-1:0]         r_gain_sum, n_gain_sum;
    logic [SUM_W-1:0]         r_loss_sum, n_loss_sum;
    logic [P-1:0]             r_prev, n_prev;
    logic [RW-1:0]            r_rsi, n_rsi;
    logic                     r_out_valid, n_out_valid;

    // Item payload in flight. A stored change is {gain flag, magnitude}.
    logic [P-1:0]             r_price, n_price;
    logic [P:0]               r_chg, n_chg;
    logic [P:0]               r_old;
    rsits_pkg::t_trade_signal r_out_signal, n_out_signal;
    logic [RW-1:0]            r_out_rsi, n_out_rsi;
    logic                     r_out_full, n_out_full;

    // Change store, one entry per window position.
    logic [P:0]               r_ring [WINDOW_MAX];

    logic                     cfg_we;
    logic                     in_accept;
    logic [CMP_W-1:0]         wl_ext;
    logic [LEN_W-1:0]         eff_len;
    logic                     full_now;
    logic [LEN_W-1:0]         slot_inc;
    logic [P:0]               chg_diff;
    logic                     chg_neg;
    logic [P-1:0]             chg_mag;
    logic                     chg_gain;
    logic                     div_start;
    logic [SUM_W-1:0]         div_total;
    rsits_pkg::t_div_res      div_res;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    // A configuration write takes precedence over an item offered in the same cycle.
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign in_accept   = i_in_valid && !o_in_stall;

    // Window length as used: zero counts as one, and it saturates at the store depth.
    assign wl_ext  = CMP_W'(r_window_length);
    assign eff_len = (wl_ext == '0)                ? LEN_W'(1) :
                     (wl_ext > CMP_W'(WINDOW_MAX)) ? LEN_W'(WINDOW_MAX) :
                                                     LEN_W'(wl_ext);

    assign full_now = (r_fill >= eff_len);
    assign slot_inc = LEN_W'(r_wslot) + LEN_W'(1);

    // Price change as a gain flag and a magnitude; a zero change counts as a loss of zero.
    assign chg_diff = {1'b0, r_price} - {1'b0, r_prev};
    assign chg_neg  = chg_diff[P];
    assign chg_mag  = chg_neg ? (~chg_diff[P-1:0] + P'(1)) : chg_diff[P-1:0];
    assign chg_gain = !chg_neg && (chg_diff != '0);

    assign div_total = r_gain_sum + r_loss_sum;

    rsits_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_gain  (r_gain_sum),
        .i_total (div_total),
        .o_res   (div_res)
    );

    always_comb begin
        n_state         = r_state;
        n_window_length = r_window_length;
        n_overbought    = r_overbought;
        n_oversold      = r_oversold;
        n_fill          = r_fill;
        n_wslot         = r_wslot;
        n_gain_sum      = r_gain_sum;
        n_loss_sum      = r_loss_sum;
        n_prev          = r_prev;
        n_rsi           = r_rsi;
        n_price         = r_price;
        n_chg           = r_chg;
        n_out_signal    = r_out_signal;
        n_out_rsi       = r_out_rsi;
        n_out_full      = r_out_full;
        n_out_valid     = r_out_valid;
        div_start       = 1'b0;

        // The waiting result leaves as soon as the receiver takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (cfg_we) begin
                    unique case (i_cfg_index)
                        rsits_pkg::CFG_WINDOW_LENGTH: begin
                            n_window_length = i_cfg_data[WL_W-1:0];
                            n_fill          = '0;
                            n_wslot         = '0;
                            n_gain_sum      = '0;
                            n_loss_sum      = '0;
                        end
                        rsits_pkg::CFG_OVERBOUGHT_LEVEL: begin
                            n_overbought = i_cfg_data[RW-1:0];
                        end
                        rsits_pkg::CFG_OVERSOLD_LEVEL: begin
                            n_oversold = i_cfg_data[RW-1:0];
                        end
                        default: begin
                        end
                    endcase
                end
                if (in_accept) begin
                    n_price = i_close_price;
                    n_wslot = (LEN_W'(r_wslot) >= eff_len) ? '0 : r_wslot;
                    if (r_prev != '0) begin
                        n_state = S_CHANGE;
                    end else begin
                        // No previous price: nothing enters the window.
                        n_prev  = i_close_price;
                        n_state = S_SIGNAL;
                    end
                end
            end
            S_CHANGE: begin
                n_chg   = {chg_gain, chg_mag};
                n_prev  = r_price;
                n_state = S_REMOVE;
            end
            S_REMOVE: begin
                // With a full window the oldest change leaves the sums.
                if (full_now) begin
                    if (r_old[P]) begin
                        n_gain_sum = r_gain_sum - SUM_W'(r_old[P-1:0]);
                    end else begin
                        n_loss_sum = r_loss_sum - SUM_W'(r_old[P-1:0]);
                    end
                end else begin
                    n_fill = r_fill + LEN_W'(1);
                end
                n_state = S_ADD;
            end
            S_ADD: begin
                if (r_chg[P]) begin
                    n_gain_sum = r_gain_sum + SUM_W'(r_chg[P-1:0]);
                end else begin
                    n_loss_sum = r_loss_sum + SUM_W'(r_chg[P-1:0]);
                end
                n_wslot = (slot_inc >= eff_len) ? '0 : slot_inc[SLOT_W-1:0];
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (full_now) begin
                    if (r_loss_sum == '0) begin
                        n_rsi   = rsits_pkg::RSI_FULL;
                        n_state = S_SIGNAL;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIVIDE;
                    end
                end else begin
                    n_state = S_SIGNAL;
                end
            end
            S_DIVIDE: begin
                if (div_res.done) begin
                    n_rsi   = div_res.quo;
                    n_state = S_SIGNAL;
                end
            end
            S_SIGNAL: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_rsi    = r_rsi;
                    n_out_full   = full_now;
                    n_out_signal = rsits_pkg::SIG_HOLD;
                    if (full_now) begin
                        if (r_rsi > r_overbought) begin
                            n_out_signal = rsits_pkg::SIG_SELL;
                        end else if (r_rsi < r_oversold) begin
                            n_out_signal = rsits_pkg::SIG_BUY;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_window_length <= rsits_pkg::WLEN_RESET;
            r_overbought    <= rsits_pkg::OVERBOUGHT_RST;
            r_oversold      <= rsits_pkg::OVERSOLD_RST;
            r_fill          <= '0;
            r_wslot         <= '0;
            r_gain_sum      <= '0;
            r_loss_sum      <= '0;
            r_prev          <= '0;
            r_rsi           <= rsits_pkg::RSI_INIT;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_window_length <= n_window_length;
            r_overbought    <= n_overbought;
            r_oversold      <= n_oversold;
            r_fill          <= n_fill;
            r_wslot         <= n_wslot;
            r_gain_sum      <= n_gain_sum;
            r_loss_sum      <= n_loss_sum;
            r_prev          <= n_prev;
            r_rsi           <= n_rsi;
            r_out_valid     <= n_out_valid;
        end
        r_price      <= n_price;
        r_chg        <= n_chg;
        r_out_signal <= n_out_signal;
        r_out_rsi    <= n_out_rsi;
        r_out_full   <= n_out_full;
    end

    // The oldest change is read while the new one is formed; the new one is written to its slot in the add step.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CHANGE) begin
            r_old <= r_ring[r_wslot];
        end
        if (r_state == S_ADD) begin
            r_ring[r_wslot] <= r_chg;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_trade_signal = r_out_signal;
    assign o_rsi_level    = r_out_rsi;
    assign o_window_full  = r_out_full;

endmodule

@@ hdl/rsits_chk.sv @@
// Port checker for the RSI threshold signal block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rsits_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [rsits_pkg::SIG_W-1:0] o_trade_signal,
    input logic [rsits_pkg::RSI_W-1:0] o_rsi_level,
    input logic                        o_window_full
);

    // A held result must not change until it is taken.
    property p_out_hold;
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_trade_signal)
            && $stable(o_rsi_level) && $stable(o_window_full);
    endproperty

    // Items are handled one at a time, so acceptance is followed by a stall.
    property p_one_item;
        i_in_valid && !o_in_stall |=> o_in_stall;
    endproperty

    // Until the window has filled the signal is always hold.
    property p_hold_unfilled;
        o_out_valid && !o_window_full |-> o_trade_signal == rsits_pkg::SIG_HOLD;
    endproperty

    // The index never exceeds one hundred percent.
    property p_rsi_range;
        o_out_valid |-> o_rsi_level <= rsits_pkg::RSI_FULL;
    endproperty

    // Reset empties the output register.
    property p_reset_out;
        !i_rst_n |=> !o_out_valid;
    endproperty

    `RSITS_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "result changed while stalled")
    `RSITS_ASSERT(a_one_item, i_clk, i_rst_n, p_one_item, "item taken while one is in progress")
    `RSITS_ASSERT(a_hold_unfilled, i_clk, i_rst_n, p_hold_unfilled, "trade before window filled")
    `RSITS_ASSERT(a_rsi_range, i_clk, i_rst_n, p_rsi_range, "RSI above full scale")
    `RSITS_ASSERT_ALWAYS(a_reset_out, i_clk, p_reset_out, "result present after reset")

endmodule

bind rsi_threshold_signal_top rsits_chk u_rsits_chk (.*);
